// ===== rtl/ack_retransmit_tracker_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef ACK_RETRANSMIT_TRACKER_UNIT_ASSERT_SVH
`define ACK_RETRANSMIT_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ACKRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ACKRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ackrt_pkg.sv =====
`default_nettype none
package ackrt_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int SEQ_W = 32;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int HANDLE_W = 16;
  localparam int ATT_W = 4;
  localparam int AGE_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd10;
  localparam logic [ATT_W-1:0] MAX_ATT_RESET = 4'd5;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [ATT_W-1:0] ATT_FIRST = 4'd1;

  // opcode three carries no meaning and is dropped
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_SENT   = 3'd0,
    EV_FULL   = 3'd1,
    EV_ACKED  = 3'd2,
    EV_RESEND = 3'd3,
    EV_GAVEUP = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_MAX_ATT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_COMMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [ADDR_W-1:0]   address;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
    logic [ATT_W-1:0]    attempts;
    logic [AGE_W-1:0]    age;
  } entry_t;

  typedef struct packed {
    event_t              event_res;
    logic [SEQ_W-1:0]    seq;
    logic                accepted;
    logic [ADDR_W-1:0]   address;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
  } evt_t;

  // verdict of the shared slot unit for one slot
  typedef struct packed {
    logic   stop;
    logic   emit;
    logic   clear;
    logic   write;
    entry_t wentry;
    evt_t   evt;
  } eval_t;

endpackage
`default_nettype wire

// ===== rtl/ackrt_if.sv =====
`default_nettype none
interface ackrt_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic [ackrt_pkg::ADDR_W-1:0]       dest_address;
  logic [ackrt_pkg::PORT_W-1:0]       dest_port;
  logic [ackrt_pkg::HANDLE_W-1:0]     message_handle;
  logic [ackrt_pkg::SEQ_W-1:0]        ack_sequence;
  logic                               ack_accepted;

  modport source (output valid, op, dest_address, dest_port, message_handle,
                  ack_sequence, ack_accepted, input ready);
  modport sink (input valid, op, dest_address, dest_port, message_handle,
                ack_sequence, ack_accepted, output ready);
endinterface

interface ackrt_evt_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         event_res;
  logic [ackrt_pkg::SEQ_W-1:0]        sequence_res;
  logic                               accepted;
  logic [ackrt_pkg::ADDR_W-1:0]       out_address;
  logic [ackrt_pkg::PORT_W-1:0]       out_port;
  logic [ackrt_pkg::HANDLE_W-1:0]     out_handle;
  logic                               last;

  modport source (output valid, event_res, sequence_res, accepted, out_address,
                  out_port, out_handle, last, input ready);
  modport sink (input valid, event_res, sequence_res, accepted, out_address,
                out_port, out_handle, last, output ready);
endinterface

interface ackrt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ackrt_pkg::CFG_IDX_W-1:0]    index;
  logic [ackrt_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ackrt_ram.sv =====
`default_nettype none
module ackrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ackrt_slot_eval.sv =====
`default_nettype none
// shared compare / age unit, looks at one slot per cycle while the scan is not stalled
module ackrt_slot_eval (
  input  wire logic [1:0]                      op,
  input  wire logic                            slot_valid,
  input  wire ackrt_pkg::entry_t               entry,
  input  wire logic [ackrt_pkg::SEQ_W-1:0]     key,
  input  wire logic                            accepted,
  input  wire logic [ackrt_pkg::AGE_W-1:0]     timeout,
  input  wire logic [ackrt_pkg::ATT_W-1:0]     max_att,
  output ackrt_pkg::eval_t                     res
);
  logic [ackrt_pkg::AGE_W-1:0] age_inc;
  logic                        seq_hit;
  logic                        due;
  logic                        give_up;

  always_comb begin
    age_inc = (entry.age == ackrt_pkg::AGE_MAX) ? entry.age
                                                : entry.age + ackrt_pkg::AGE_W'(1);
    seq_hit = slot_valid && (entry.seq == key);
    due     = !(age_inc < timeout);
    give_up = !(entry.attempts < max_att);

    res               = '0;
    res.wentry        = entry;
    res.evt.event_res = ackrt_pkg::EV_SENT;
    unique case (op)
      ackrt_pkg::OP_SEND: begin
        res.stop = seq_hit;
      end
      ackrt_pkg::OP_ACK: begin
        res.stop              = seq_hit;
        res.emit              = seq_hit;
        res.clear             = seq_hit;
        res.evt.event_res     = ackrt_pkg::EV_ACKED;
        res.evt.seq           = key;
        res.evt.accepted      = accepted;
      end
      ackrt_pkg::OP_TICK: begin
        res.evt.seq = entry.seq;
        if (slot_valid && due && give_up) begin
          res.emit          = 1'b1;
          res.clear         = 1'b1;
          res.evt.event_res = ackrt_pkg::EV_GAVEUP;
        end else if (slot_valid && due) begin
          res.emit            = 1'b1;
          res.write           = 1'b1;
          res.wentry.attempts = entry.attempts + ackrt_pkg::ATT_W'(1);
          res.wentry.age      = '0;
          res.evt.event_res   = ackrt_pkg::EV_RESEND;
          res.evt.address     = entry.address;
          res.evt.port        = entry.port;
          res.evt.handle      = entry.handle;
        end else begin
          res.write      = slot_valid;
          res.wentry.age = age_inc;
        end
      end
      default: begin
        res.stop = 1'b0;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/ack_retransmit_tracker_unit.sv =====
`default_nettype none
// channel  role   carries
// cfg      sink   register index and write data, always ready
// cmd      sink   op, destination, handle, ack sequence and flag
// evt      source event, sequence, flag, destination, handle, last
//
// a send, ack or tick scans the table one slot per unstalled cycle through the slot ram:
// take the word, prime the ram read, scan up to TABLE_SLOTS slots,
// commit the entry for a send only, then flush
// an ack stops at the matching slot, opcode three returns to idle at once
// rst is synchronous, clears valid bits and sequence counter, resets registers
// events wait in a one-deep pending stage so the final one can carry last;
// a scan stalls only when a new event meets a full pending stage and an output
// word that is not taken, and the flush waits for the output the same way
module ack_retransmit_tracker_unit #(
  parameter int TABLE_SLOTS = ackrt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ackrt_cfg_if.sink   cfg,
  ackrt_cmd_if.sink   cmd,
  ackrt_evt_if.source evt
);
  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);

  ackrt_pkg::state_t state, state_next;

  // latched command word
  logic [1:0]                          op_q;
  logic [ackrt_pkg::ADDR_W-1:0]        addr_q;
  logic [ackrt_pkg::PORT_W-1:0]        port_q;
  logic [ackrt_pkg::HANDLE_W-1:0]      handle_q;
  logic [ackrt_pkg::SEQ_W-1:0]         ackseq_q;
  logic                                ackacc_q;

  // configuration
  logic [ackrt_pkg::AGE_W-1:0]         timeout;
  logic [ackrt_pkg::ATT_W-1:0]         max_att;

  // table control
  logic [TABLE_SLOTS-1:0]              valid;
  logic [ackrt_pkg::SEQ_W-1:0]         next_seq;
  logic [IW-1:0]                       scan;
  logic                                match_found;
  logic [IW-1:0]                       match_slot;
  logic                                free_found;
  logic [IW-1:0]                       free_slot;

  // event staging
  logic                                pend_valid;
  ackrt_pkg::evt_t                     pend;
  logic                                out_valid;
  ackrt_pkg::evt_t                     out_evt;
  logic                                out_last;

  // ram and shared unit hookup
  logic                                ram_we;
  logic [IW-1:0]                       ram_waddr;
  ackrt_pkg::entry_t                   ram_wdata;
  logic [IW-1:0]                       ram_raddr;
  logic [$bits(ackrt_pkg::entry_t)-1:0] ram_rdata;
  ackrt_pkg::entry_t                   rd_entry;
  ackrt_pkg::eval_t                    ev;
  logic [ackrt_pkg::SEQ_W-1:0]         key;

  // handshake and sequencing controls
  logic                                take;
  logic                                out_free;
  logic                                stall;
  logic                                scan_end;
  logic                                found;
  logic [IW-1:0]                       commit_slot;
  ackrt_pkg::evt_t                     commit_evt;
  logic                                push_new;
  ackrt_pkg::evt_t                     new_evt;
  logic                                move_out;
  logic                                move_last;

  assign rd_entry = ackrt_pkg::entry_t'(ram_rdata);
  assign key      = (op_q == ackrt_pkg::OP_SEND) ? next_seq : ackseq_q;

  ackrt_ram #(
    .WIDTH ($bits(ackrt_pkg::entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ackrt_slot_eval u_eval (
    .op         (op_q),
    .slot_valid (valid[scan]),
    .entry      (rd_entry),
    .key        (key),
    .accepted   (ackacc_q),
    .timeout    (timeout),
    .max_att    (max_att),
    .res        (ev)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ackrt_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.op == ackrt_pkg::OP_NOP) ? ackrt_pkg::ST_IDLE
                                                      : ackrt_pkg::ST_PRIME;
        end
      end
      ackrt_pkg::ST_PRIME: begin
        state_next = ackrt_pkg::ST_SCAN;
      end
      ackrt_pkg::ST_SCAN: begin
        if (!stall && scan_end) begin
          state_next = (op_q == ackrt_pkg::OP_SEND) ? ackrt_pkg::ST_COMMIT
                                                     : ackrt_pkg::ST_FLUSH;
        end
      end
      ackrt_pkg::ST_COMMIT: begin
        state_next = ackrt_pkg::ST_FLUSH;
      end
      ackrt_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ackrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ackrt_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    cmd.ready = (state == ackrt_pkg::ST_IDLE);
    take      = cmd.valid && cmd.ready;
    out_free  = !out_valid || evt.ready;
    stall     = (state == ackrt_pkg::ST_SCAN) && ev.emit && pend_valid && !out_free;
    scan_end  = ev.stop || (scan == LAST_SLOT);

    // an existing entry with the same sequence wins over the lowest free slot
    found       = match_found || free_found;
    commit_slot = match_found ? match_slot : free_slot;

    commit_evt = '0;
    if (found) begin
      commit_evt.event_res = ackrt_pkg::EV_SENT;
      commit_evt.seq       = next_seq;
      commit_evt.address   = addr_q;
      commit_evt.port      = port_q;
      commit_evt.handle    = handle_q;
    end else begin
      commit_evt.event_res = ackrt_pkg::EV_FULL;
    end

    ram_raddr = scan;
    ram_we    = 1'b0;
    ram_waddr = scan;
    ram_wdata = ev.wentry;
    push_new  = 1'b0;
    new_evt   = ev.evt;
    move_out  = 1'b0;
    move_last = 1'b0;

    unique case (state)
      ackrt_pkg::ST_SCAN: begin
        if (!stall) begin
          ram_raddr = scan + IW'(1);
          ram_we    = ev.write;
          push_new  = ev.emit;
          move_out  = ev.emit && pend_valid;
        end
      end
      ackrt_pkg::ST_COMMIT: begin
        ram_we             = found;
        ram_waddr          = commit_slot;
        ram_wdata.seq      = next_seq;
        ram_wdata.address  = addr_q;
        ram_wdata.port     = port_q;
        ram_wdata.handle   = handle_q;
        ram_wdata.attempts = ackrt_pkg::ATT_FIRST;
        ram_wdata.age      = '0;
        push_new           = 1'b1;
        new_evt            = commit_evt;
      end
      ackrt_pkg::ST_FLUSH: begin
        move_out  = pend_valid && out_free;
        move_last = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ackrt_pkg::ST_IDLE;
      timeout     <= ackrt_pkg::TIMEOUT_RESET;
      max_att     <= ackrt_pkg::MAX_ATT_RESET;
      valid       <= '0;
      next_seq    <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        unique case (ackrt_pkg::cfg_idx_t'(cfg.index))
          ackrt_pkg::CFG_TIMEOUT: timeout <= cfg.data;
          ackrt_pkg::CFG_MAX_ATT: max_att <= cfg.data[ackrt_pkg::ATT_W-1:0];
        endcase
      end

      if (take) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end

      if (state == ackrt_pkg::ST_SCAN && !stall) begin
        if (ev.clear) begin
          valid[scan] <= 1'b0;
        end
        if (op_q == ackrt_pkg::OP_SEND) begin
          if (ev.stop) begin
            match_found <= 1'b1;
          end
          if (!valid[scan] && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end

      if (state == ackrt_pkg::ST_COMMIT && found) begin
        valid[commit_slot] <= 1'b1;
        next_seq           <= next_seq + ackrt_pkg::SEQ_W'(1);
      end

      if (push_new) begin
        pend_valid <= 1'b1;
      end else if (move_out) begin
        pend_valid <= 1'b0;
      end

      out_valid <= move_out || (out_valid && !evt.ready);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      op_q     <= cmd.op;
      addr_q   <= cmd.dest_address;
      port_q   <= cmd.dest_port;
      handle_q <= cmd.message_handle;
      ackseq_q <= cmd.ack_sequence;
      ackacc_q <= cmd.ack_accepted;
      scan     <= '0;
    end else if (state == ackrt_pkg::ST_SCAN && !stall && !scan_end) begin
      scan <= scan + IW'(1);
    end

    if (state == ackrt_pkg::ST_SCAN && !stall && op_q == ackrt_pkg::OP_SEND) begin
      if (ev.stop) begin
        match_slot <= scan;
      end
      if (!valid[scan] && !free_found) begin
        free_slot <= scan;
      end
    end

    if (push_new) begin
      pend <= new_evt;
    end
    if (move_out) begin
      out_evt  <= pend;
      out_last <= move_last;
    end
  end

  assign cfg.ready        = 1'b1;
  assign evt.valid        = out_valid;
  assign evt.event_res    = out_evt.event_res;
  assign evt.sequence_res = out_evt.seq;
  assign evt.accepted     = out_evt.accepted;
  assign evt.out_address  = out_evt.address;
  assign evt.out_port     = out_evt.port;
  assign evt.out_handle   = out_evt.handle;
  assign evt.last         = out_last;
endmodule
`default_nettype wire

// ===== rtl/ackrt_checker.sv =====
`default_nettype none
`include "ack_retransmit_tracker_unit_assert.svh"
module ackrt_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cmd_valid,
  input wire logic                          cmd_ready,
  input wire logic [1:0]                    cmd_op,
  input wire logic                          evt_valid,
  input wire logic                          evt_ready,
  input wire logic [2:0]                    evt_event_res,
  input wire logic [ackrt_pkg::SEQ_W-1:0]   evt_sequence_res,
  input wire logic                          evt_last
);
  // a waiting event keeps its word
  `ACKRT_ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready, evt_valid && $stable(evt_event_res) && $stable(evt_sequence_res) && $stable(evt_last), "event word changed while stalled")

  // a real command keeps the block busy for the scan
  `ACKRT_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready && cmd_op != ackrt_pkg::OP_NOP, !cmd_ready, "ready right after a scanning command")

  // the meaningless opcode is dropped without a scan
  `ACKRT_ASSERT_NEXT(a_nop_returns, cmd_valid && cmd_ready && cmd_op == ackrt_pkg::OP_NOP, cmd_ready, "not ready after a dropped opcode")
endmodule

bind ack_retransmit_tracker_unit ackrt_checker u_ackrt_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_op           (cmd.op),
  .evt_valid        (evt.valid),
  .evt_ready        (evt.ready),
  .evt_event_res    (evt.event_res),
  .evt_sequence_res (evt.sequence_res),
  .evt_last         (evt.last)
);
`default_nettype wire

// ===== bench/ack_retransmit_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
module ack_retransmit_tracker_unit_tb;
  import ackrt_pkg::*;

  localparam int SLOTS           = TABLE_SLOTS_DEF;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int N_PHASES        = 6;
  // settle time that covers the scan of a word with no event
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int WAIT_CAP        = 200000;
  localparam int CYCLE_LIMIT     = 1000000;

  // one command word as it crosses the cmd channel
  typedef struct packed {
    logic [1:0]          op;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
    logic [SEQ_W-1:0]    ack_seq;
    logic                ack_acc;
  } cmd_word_t;

  // one event word as it leaves on the evt channel
  typedef struct packed {
    event_t              kind;
    logic [SEQ_W-1:0]    seq;
    logic                acc;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } report_t;

  // a command plus, for directed rows, the single event it must give (n_out 0 or 1)
  typedef struct {
    cmd_word_t        w;
    bit               typed;
    int unsigned      n_out;
    event_t           kind;
    logic [SEQ_W-1:0] seq;
    logic             acc;
  } plan_row_t;

  logic clk;
  logic rst;

  ackrt_cfg_if cfg_bus ();
  ackrt_cmd_if cmd_bus ();
  ackrt_evt_if evt_bus ();

  ack_retransmit_tracker_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .cmd (cmd_bus),
    .evt (evt_bus)
  );

  // tracker state as this bench sees it
  logic [AGE_W-1:0] timeout_reg;
  logic [ATT_W-1:0] max_att_reg;
  logic             live [SLOTS];
  entry_t           tab [SLOTS];
  logic [SEQ_W-1:0] next_seq;

  report_t   fresh_events[$];
  report_t   awaited_events[$];
  plan_row_t row_marks[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_off = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic report_t make_report(event_t kind, logic [SEQ_W-1:0] seq, logic acc,
                                          logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                                          logic [HANDLE_W-1:0] handle);
    return '{kind: kind, seq: seq, acc: acc, addr: addr, port: port, handle: handle,
             last: 1'b0};
  endfunction

  function automatic string show(report_t r);
    return $sformatf("ev %0d seq %h acc %b addr %h port %h handle %h last %b",
                     r.kind, r.seq, r.acc, r.addr, r.port, r.handle, r.last);
  endfunction

  // events caused by one accepted command, left in fresh_events
  function automatic void track_command(cmd_word_t w);
    int i;
    int slot;
    fresh_events.delete();
    slot = -1;
    if (w.op == OP_SEND) begin
      // a live entry holding the same sequence is reused, else the lowest free slot
      for (i = 0; i < SLOTS; i++)
        if (slot < 0 && live[i] && tab[i].seq == next_seq) slot = i;
      for (i = 0; i < SLOTS; i++)
        if (slot < 0 && !live[i]) slot = i;
      if (slot < 0) begin
        fresh_events.push_back(make_report(EV_FULL, '0, 1'b0, '0, '0, '0));
      end else begin
        live[slot] = 1'b1;
        tab[slot] = '{seq: next_seq, address: w.addr, port: w.port, handle: w.handle,
                      attempts: ATT_FIRST, age: '0};
        fresh_events.push_back(make_report(EV_SENT, next_seq, 1'b0, w.addr, w.port,
                                           w.handle));
        next_seq = next_seq + 1'b1;
      end
    end else if (w.op == OP_ACK) begin
      for (i = 0; i < SLOTS; i++)
        if (slot < 0 && live[i] && tab[i].seq == w.ack_seq) slot = i;
      if (slot >= 0) begin
        live[slot] = 1'b0;
        fresh_events.push_back(make_report(EV_ACKED, w.ack_seq, w.ack_acc, '0, '0, '0));
      end
    end else if (w.op == OP_TICK) begin
      for (i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          if (tab[i].age != AGE_MAX) tab[i].age = tab[i].age + 1'b1;
          if (tab[i].age >= timeout_reg) begin
            if (tab[i].attempts >= max_att_reg) begin
              live[i] = 1'b0;
              fresh_events.push_back(make_report(EV_GAVEUP, tab[i].seq, 1'b0, '0, '0, '0));
            end else begin
              tab[i].attempts = tab[i].attempts + 1'b1;
              tab[i].age = '0;
              fresh_events.push_back(make_report(EV_RESEND, tab[i].seq, 1'b0,
                                                 tab[i].address, tab[i].port,
                                                 tab[i].handle));
            end
          end
        end
      end
    end
    if (fresh_events.size() > 0) fresh_events[fresh_events.size() - 1].last = 1'b1;
  endfunction

  // watch all three channels; a command word is predicted before any event is checked
  always @(posedge clk) begin : watch
    plan_row_t mark;
    cmd_word_t seen;
    report_t   one;
    report_t   got;
    report_t   want;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == CFG_TIMEOUT) timeout_reg = cfg_bus.data;
        else max_att_reg = cfg_bus.data[ATT_W-1:0];
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        mark = row_marks.pop_front();
        seen = '{op: cmd_bus.op, addr: cmd_bus.dest_address, port: cmd_bus.dest_port,
                 handle: cmd_bus.message_handle, ack_seq: cmd_bus.ack_sequence,
                 ack_acc: cmd_bus.ack_accepted};
        track_command(seen);
        // directed rows carry their own answer in place of the prediction
        if (mark.typed) begin
          fresh_events.delete();
          if (mark.n_out != 0) begin
            if (mark.kind == EV_SENT)
              one = make_report(mark.kind, mark.seq, mark.acc, mark.w.addr, mark.w.port,
                                mark.w.handle);
            else
              one = make_report(mark.kind, mark.seq, mark.acc, '0, '0, '0);
            one.last = 1'b1;
            fresh_events.push_back(one);
          end
        end
        foreach (fresh_events[k]) awaited_events.push_back(fresh_events[k]);
      end
      if (evt_bus.valid && evt_bus.ready) begin
        got = '{kind: event_t'(evt_bus.event_res), seq: evt_bus.sequence_res,
                acc: evt_bus.accepted, addr: evt_bus.out_address, port: evt_bus.out_port,
                handle: evt_bus.out_handle, last: evt_bus.last};
        if (awaited_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %s", $time, show(got));
          errors++;
        end else begin
          want = awaited_events.pop_front();
          if (got !== want) begin
            $display("%0t: event mismatch, expected %s, actual %s", $time, show(want),
                     show(got));
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to fill the tracker up
  initial begin
    evt_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        evt_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      evt_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("FAIL ack_retransmit_tracker_unit");
      $finish;
    end
  end

  function automatic cmd_word_t word(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                     logic [PORT_W-1:0] port, logic [HANDLE_W-1:0] handle,
                                     logic [SEQ_W-1:0] ack_seq, logic ack_acc);
    return '{op: op, addr: addr, port: port, handle: handle, ack_seq: ack_seq,
             ack_acc: ack_acc};
  endfunction

  function automatic plan_row_t directed(cmd_word_t w, int unsigned n_out, event_t kind,
                                         logic [SEQ_W-1:0] seq, logic acc);
    return '{w: w, typed: 1'b1, n_out: n_out, kind: kind, seq: seq, acc: acc};
  endfunction

  // mostly sends, acks of messages in flight and ticks; some stray acks and opcode three
  function automatic cmd_word_t random_word();
    cmd_word_t   w;
    int          i;
    int          pick;
    int          n_live;
    int unsigned roll;
    w = word(OP_TICK, $urandom, 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), $urandom, 1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      w.op = OP_SEND;
    end else if (roll < 65) begin
      w.op = OP_ACK;
      n_live = 0;
      for (i = 0; i < SLOTS; i++)
        if (live[i]) n_live++;
      if (n_live > 0 && $urandom_range(0, 99) < 80) begin
        pick = $urandom_range(0, n_live - 1);
        for (i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            if (pick == 0) w.ack_seq = tab[i].seq;
            pick--;
          end
        end
      end else if ($urandom_range(0, 1) == 0) begin
        // near miss: a sequence not handed out yet
        w.ack_seq = next_seq + $urandom_range(0, 3);
      end
    end else if (roll >= 95) begin
      w.op = OP_NOP;
    end
    return w;
  endfunction

  // offer one word and return at the edge that takes it
  task automatic offer_word(input plan_row_t mark);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.op             <= mark.w.op;
    cmd_bus.dest_address   <= mark.w.addr;
    cmd_bus.dest_port      <= mark.w.port;
    cmd_bus.message_handle <= mark.w.handle;
    cmd_bus.ack_sequence   <= mark.w.ack_seq;
    cmd_bus.ack_accepted   <= mark.w.ack_acc;
    row_marks.push_back(mark);
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // stop offering, let every awaited event drain, then let a silent scan finish
  task automatic settle();
    int n;
    cmd_bus.valid <= 1'b0;
    for (n = 0; n < WAIT_CAP && (awaited_events.size() != 0 || row_marks.size() != 0); n++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, valid held high between them
  task automatic write_regs(input logic [AGE_W-1:0] ticks, input logic [ATT_W-1:0] att);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_TIMEOUT;
    cfg_bus.data  <= ticks;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.index <= CFG_MAX_ATT;
    cfg_bus.data  <= CFG_DATA_W'(att);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    plan_row_t        plan[$];
    plan_row_t        plain;
    cmd_word_t        w;
    logic [AGE_W-1:0] phase_ticks;
    logic [ATT_W-1:0] phase_att;
    int               ph;
    int               k;
    int               taken;

    // every input known from time zero
    rst                    <= 1'b1;
    cmd_bus.valid          <= 1'b0;
    cmd_bus.op             <= OP_SEND;
    cmd_bus.dest_address   <= '0;
    cmd_bus.dest_port      <= '0;
    cmd_bus.message_handle <= '0;
    cmd_bus.ack_sequence   <= '0;
    cmd_bus.ack_accepted   <= 1'b0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= CFG_TIMEOUT;
    cfg_bus.data           <= '0;

    // tracker after reset: empty table, default registers
    timeout_reg = TIMEOUT_RESET;
    max_att_reg = MAX_ATT_RESET;
    next_seq    = '0;
    for (k = 0; k < SLOTS; k++) begin
      live[k] = 1'b0;
      tab[k]  = '0;
    end
    plain = '{w: '0, typed: 1'b0, n_out: 0, kind: EV_SENT, seq: '0, acc: 1'b0};

    // directed words, default timeout 10 and 5 attempts
    // tick and ack on an empty table, opcode three: nothing comes out
    plan.push_back(directed(word(OP_TICK, '0, '0, '0, '0, 1'b0), 0, EV_SENT, '0, 1'b0));
    plan.push_back(directed(word(OP_ACK, '0, '0, '0, '1, 1'b1), 0, EV_SENT, '0, 1'b0));
    plan.push_back(directed(word(OP_NOP, '1, '1, '1, '1, 1'b1), 0, EV_SENT, '0, 1'b0));
    // sends with all-ones and all-zero fields take sequences 0 and 1
    plan.push_back(directed(word(OP_SEND, '1, '1, '1, '0, 1'b0), 1, EV_SENT, 32'd0, 1'b0));
    plan.push_back(directed(word(OP_SEND, '0, '0, '0, '1, 1'b1), 1, EV_SENT, 32'd1, 1'b0));
    // acks with either flag remove them again
    plan.push_back(directed(word(OP_ACK, '0, '0, '0, 32'd0, 1'b1), 1, EV_ACKED, 32'd0, 1'b1));
    plan.push_back(directed(word(OP_ACK, '1, '1, '1, 32'd1, 1'b0), 1, EV_ACKED, 32'd1, 1'b0));
    // fill every slot with sequences 2 to 17
    for (k = 0; k < SLOTS; k++)
      plan.push_back(directed(word(OP_SEND, 32'h0a000000 | k, 16'(1000 + k), 16'(k), '0,
                                   1'b0), 1, EV_SENT, 32'(2 + k), 1'b0));
    // table full: rejected with all fields zero
    plan.push_back(directed(word(OP_SEND, '1, '1, '1, '0, 1'b0), 1, EV_FULL, '0, 1'b0));
    // nothing is due yet
    plan.push_back(directed(word(OP_TICK, '1, '1, '1, '1, 1'b1), 0, EV_SENT, '0, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < plan.size(); k++) offer_word(plan[k]);

    // random phases, each with its own registers and pacing
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          // zero timeout and zero attempts: the full table gives up at the first tick
          phase_ticks = '0;
          phase_att   = '0;
        end
        1: begin
          phase_ticks = 16'd1;
          phase_att   = 4'd15;
        end
        2: begin
          // nothing comes due within the phase, so the table fills and sends get rejected
          phase_ticks = AGE_MAX;
          phase_att   = 4'd1;
        end
        3: begin
          phase_ticks = 16'd3;
          phase_att   = 4'd2;
        end
        4: begin
          phase_ticks = 16'd2;
          phase_att   = 4'd4;
        end
        default: begin
          phase_ticks = 16'($urandom_range(1, 6));
          phase_att   = 4'($urandom_range(1, 15));
        end
      endcase
      write_regs(phase_ticks, phase_att);
      case (ph)
        1: begin
          tx_idle_pct  = 56;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 56;
          hold_off     = 1'b1;
        end
        3, 5: begin
          tx_idle_pct  = 28;
          rx_stall_pct = 28;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      taken = 0;
      while (taken < ITEMS_PER_PHASE) begin
        w = random_word();
        plain.w = w;
        offer_word(plain);
        if (w.op != OP_NOP) taken++;
      end
    end

    settle();
    if (awaited_events.size() != 0) begin
      $display("%0t: %0d events never came, expected %s, actual none", $time,
               awaited_events.size(), show(awaited_events[0]));
      errors++;
    end
    if (errors == 0) begin
      $display("PASS ack_retransmit_tracker_unit");
    end else begin
      $display("FAIL ack_retransmit_tracker_unit");
    end
    $finish;
  end

endmodule
